[rtl/osmc_pkg.sv]
// shared types, constants and helpers for the opcode sample match counter
// no dependencies; imported by every rtl module and the port checker
package osmc_pkg;

   localparam int REG_WIDTH     = 32;
   localparam int FIELD_WIDTH   = 32;
   localparam int OPND_WIDTH    = 16;
   localparam int NUM_REGS      = 4;
   localparam int REG_IDX_WIDTH = $clog2(NUM_REGS);
   localparam int NUM_OPS       = 16;
   localparam int COUNT_WIDTH   = $clog2(NUM_OPS + 1);

   // operation codes, bit position in the match mask
   localparam int OP_ADDR = 0;
   localparam int OP_ADDI = 1;
   localparam int OP_MULR = 2;
   localparam int OP_MULI = 3;
   localparam int OP_BANR = 4;
   localparam int OP_BANI = 5;
   localparam int OP_BORR = 6;
   localparam int OP_BORI = 7;
   localparam int OP_SETR = 8;
   localparam int OP_SETI = 9;
   localparam int OP_GTIR = 10;
   localparam int OP_GTRI = 11;
   localparam int OP_GTRR = 12;
   localparam int OP_EQIR = 13;
   localparam int OP_EQRI = 14;
   localparam int OP_EQRR = 15;

   typedef logic [REG_WIDTH-1:0]   reg_word_type;
   typedef logic [OPND_WIDTH-1:0]  opnd_type;
   typedef logic [NUM_OPS-1:0]     op_mask_type;
   typedef logic [COUNT_WIDTH-1:0] op_count_type;

   // one captured sample, register values already at register width
   typedef struct packed {
      reg_word_type [NUM_REGS-1:0] prior;
      reg_word_type [NUM_REGS-1:0] after;
      opnd_type                    a;
      opnd_type                    b;
      opnd_type                    c;
   } sample_type;

   // selected operands plus the index checks
   typedef struct packed {
      reg_word_type ra;
      reg_word_type rb;
      reg_word_type ia;
      reg_word_type ib;
      reg_word_type target;
      logic         a_ok;
      logic         b_ok;
      logic         c_ok;
      logic         rest_ok;
   } operand_type;

   // sixteen candidate results and the checks that gate them
   typedef struct packed {
      reg_word_type [NUM_OPS-1:0] res;
      reg_word_type               target;
      logic                       a_ok;
      logic                       b_ok;
      logic                       c_ok;
      logic                       rest_ok;
   } result_type;

   // 32-bit field sign-extended or truncated to register width
   function automatic reg_word_type load_reg(logic signed [FIELD_WIDTH-1:0] raw);
      logic signed [63:0] wide;
      wide = 64'(raw);
      return reg_word_type'(wide);
   endfunction

   // immediate operand, unsigned, reduced to register width
   function automatic reg_word_type load_imm(opnd_type raw);
      logic [63:0] wide;
      wide = 64'(raw);
      return reg_word_type'(wide);
   endfunction

endpackage

[rtl/osmc_operand_stage.sv]
// capture stage and operand selection for the opcode sample match counter
// depends on osmc_pkg
module osmc_operand_stage
   import osmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  sample_type  in_sample,
   output logic        out_valid,
   input  logic        out_ready,
   output operand_type out_opnd
);

   logic       valid_ff;
   sample_type sample_ff;
   logic [REG_IDX_WIDTH-1:0] a_idx, b_idx, c_idx;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sample_ff <= in_sample;
      end
   end

   assign a_idx = sample_ff.a[REG_IDX_WIDTH-1:0];
   assign b_idx = sample_ff.b[REG_IDX_WIDTH-1:0];
   assign c_idx = sample_ff.c[REG_IDX_WIDTH-1:0];

   always_comb begin
      out_opnd.ra      = sample_ff.prior[a_idx];
      out_opnd.rb      = sample_ff.prior[b_idx];
      out_opnd.ia      = load_imm(sample_ff.a);
      out_opnd.ib      = load_imm(sample_ff.b);
      out_opnd.target  = sample_ff.after[c_idx];
      out_opnd.a_ok    = (sample_ff.a < opnd_type'(NUM_REGS));
      out_opnd.b_ok    = (sample_ff.b < opnd_type'(NUM_REGS));
      out_opnd.c_ok    = (sample_ff.c < opnd_type'(NUM_REGS));
      // registers other than the destination must be untouched
      out_opnd.rest_ok = 1'b1;
      for (int i = 0; i < NUM_REGS; i++) begin
         if ((c_idx != REG_IDX_WIDTH'(i)) && (sample_ff.prior[i] != sample_ff.after[i])) begin
            out_opnd.rest_ok = 1'b0;
         end
      end
   end

   assign out_valid = valid_ff;

endmodule

[rtl/osmc_alu_stage.sv]
// operand register and the sixteen operation units, results registered
// depends on osmc_pkg
module osmc_alu_stage
   import osmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  operand_type in_opnd,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  out_res
);

   logic        opnd_valid_ff;
   operand_type opnd_ff;
   logic        res_valid_ff;
   result_type  res_ff;
   result_type  res_in;
   logic        res_ready;

   assign res_ready = !res_valid_ff || out_ready;
   assign in_ready  = !opnd_valid_ff || res_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         opnd_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            opnd_valid_ff <= in_valid;
         end
         if (res_ready) begin
            res_valid_ff <= opnd_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         opnd_ff <= in_opnd;
      end
      if (res_ready && opnd_valid_ff) begin
         res_ff <= res_in;
      end
   end

   always_comb begin
      res_in.res[OP_ADDR] = reg_word_type'(opnd_ff.ra + opnd_ff.rb);
      res_in.res[OP_ADDI] = reg_word_type'(opnd_ff.ra + opnd_ff.ib);
      res_in.res[OP_MULR] = reg_word_type'(opnd_ff.ra * opnd_ff.rb);
      res_in.res[OP_MULI] = reg_word_type'(opnd_ff.ra * opnd_ff.ib);
      res_in.res[OP_BANR] = opnd_ff.ra & opnd_ff.rb;
      res_in.res[OP_BANI] = opnd_ff.ra & opnd_ff.ib;
      res_in.res[OP_BORR] = opnd_ff.ra | opnd_ff.rb;
      res_in.res[OP_BORI] = opnd_ff.ra | opnd_ff.ib;
      res_in.res[OP_SETR] = opnd_ff.ra;
      res_in.res[OP_SETI] = opnd_ff.ia;
      res_in.res[OP_GTIR] = reg_word_type'($signed(opnd_ff.ia) > $signed(opnd_ff.rb));
      res_in.res[OP_GTRI] = reg_word_type'($signed(opnd_ff.ra) > $signed(opnd_ff.ib));
      res_in.res[OP_GTRR] = reg_word_type'($signed(opnd_ff.ra) > $signed(opnd_ff.rb));
      res_in.res[OP_EQIR] = reg_word_type'(opnd_ff.ia == opnd_ff.rb);
      res_in.res[OP_EQRI] = reg_word_type'(opnd_ff.ra == opnd_ff.ib);
      res_in.res[OP_EQRR] = reg_word_type'(opnd_ff.ra == opnd_ff.rb);
      res_in.target       = opnd_ff.target;
      res_in.a_ok         = opnd_ff.a_ok;
      res_in.b_ok         = opnd_ff.b_ok;
      res_in.c_ok         = opnd_ff.c_ok;
      res_in.rest_ok      = opnd_ff.rest_ok;
   end

   assign out_valid = res_valid_ff;
   assign out_res   = res_ff;

endmodule

[rtl/osmc_compare_stage.sv]
// compares each candidate with the observed destination, registers the mask
// depends on osmc_pkg
module osmc_compare_stage
   import osmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  result_type  in_res,
   output logic        out_valid,
   input  logic        out_ready,
   output op_mask_type out_mask
);

   logic        valid_ff;
   op_mask_type mask_ff;
   op_mask_type mask_in;
   op_mask_type legal;

   assign in_ready = !valid_ff || out_ready;

   // which operations have usable indexes for this sample
   always_comb begin
      legal[OP_ADDR] = in_res.a_ok && in_res.b_ok;
      legal[OP_ADDI] = in_res.a_ok;
      legal[OP_MULR] = in_res.a_ok && in_res.b_ok;
      legal[OP_MULI] = in_res.a_ok;
      legal[OP_BANR] = in_res.a_ok && in_res.b_ok;
      legal[OP_BANI] = in_res.a_ok;
      legal[OP_BORR] = in_res.a_ok && in_res.b_ok;
      legal[OP_BORI] = in_res.a_ok;
      legal[OP_SETR] = in_res.a_ok;
      legal[OP_SETI] = 1'b1;
      legal[OP_GTIR] = in_res.b_ok;
      legal[OP_GTRI] = in_res.a_ok;
      legal[OP_GTRR] = in_res.a_ok && in_res.b_ok;
      legal[OP_EQIR] = in_res.b_ok;
      legal[OP_EQRI] = in_res.a_ok;
      legal[OP_EQRR] = in_res.a_ok && in_res.b_ok;
      for (int k = 0; k < NUM_OPS; k++) begin
         mask_in[k] = legal[k] && in_res.c_ok && in_res.rest_ok
                      && (in_res.res[k] == in_res.target);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         mask_ff <= mask_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_mask  = mask_ff;

endmodule

[rtl/opcode_sample_match_counter.sv]
// top level of the opcode sample match counter
// depends on osmc_pkg, osmc_operand_stage, osmc_alu_stage, osmc_compare_stage
//
// takes one sample per transfer (register file before, operands a, b, c,
// register file after), tries all sixteen operations of the four-register
// machine on the before state and returns the mask of operations that give
// the after state together with its population count. sums and products wrap
// at the register width, greater-than is signed, and an operation that names
// a register index of four or more, or a destination of four or more, never
// matches. the block keeps no state between samples and accepts one sample
// every cycle while req_ready is high; a sample passes through the registered
// stages before its result can be taken out (capture, operand
// select, operation units incl. the two multipliers, compare, count). each
// stage holds its item while the stage after it is full, so a stalled result
// lets the earlier stages keep filling; ready on the request side depends
// combinationally on the stage occupancy down to rsp_ready.
module opcode_sample_match_counter
   import osmc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [FIELD_WIDTH-1:0] req_before_r0,
   input  logic signed [FIELD_WIDTH-1:0] req_before_r1,
   input  logic signed [FIELD_WIDTH-1:0] req_before_r2,
   input  logic signed [FIELD_WIDTH-1:0] req_before_r3,
   input  logic        [OPND_WIDTH-1:0]  req_operand_a,
   input  logic        [OPND_WIDTH-1:0]  req_operand_b,
   input  logic        [OPND_WIDTH-1:0]  req_operand_c,
   input  logic signed [FIELD_WIDTH-1:0] req_after_r0,
   input  logic signed [FIELD_WIDTH-1:0] req_after_r1,
   input  logic signed [FIELD_WIDTH-1:0] req_after_r2,
   input  logic signed [FIELD_WIDTH-1:0] req_after_r3,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic        [NUM_OPS-1:0]     rsp_match_mask,
   output logic        [COUNT_WIDTH-1:0] rsp_match_count
);

   sample_type  sample;
   logic        opnd_valid, opnd_ready;
   operand_type opnd;
   logic        res_valid, res_ready;
   result_type  res;
   logic        cmp_valid, cmp_ready;
   op_mask_type cmp_mask;

   logic         out_valid_ff;
   op_mask_type  out_mask_ff;
   op_count_type out_count_ff;

   // register fields brought to register width on the way in
   always_comb begin
      sample.prior[0] = load_reg(req_before_r0);
      sample.prior[1] = load_reg(req_before_r1);
      sample.prior[2] = load_reg(req_before_r2);
      sample.prior[3] = load_reg(req_before_r3);
      sample.after[0] = load_reg(req_after_r0);
      sample.after[1] = load_reg(req_after_r1);
      sample.after[2] = load_reg(req_after_r2);
      sample.after[3] = load_reg(req_after_r3);
      sample.a        = req_operand_a;
      sample.b        = req_operand_b;
      sample.c        = req_operand_c;
   end

   // stage 1: capture, then operand select and index checks
   osmc_operand_stage u_operand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_sample (sample),
      .out_valid (opnd_valid),
      .out_ready (opnd_ready),
      .out_opnd  (opnd)
   );

   // stages 2 and 3: operand register, then registered operation results
   osmc_alu_stage u_alu (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (opnd_valid),
      .in_ready  (opnd_ready),
      .in_opnd   (opnd),
      .out_valid (res_valid),
      .out_ready (res_ready),
      .out_res   (res)
   );

   // stage 4: compare against the after state
   osmc_compare_stage u_compare (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_res    (res),
      .out_valid (cmp_valid),
      .out_ready (cmp_ready),
      .out_mask  (cmp_mask)
   );

   // stage 5: count and output register
   assign cmp_ready = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmp_ready) begin
         out_valid_ff <= cmp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_ready && cmp_valid) begin
         out_mask_ff  <= cmp_mask;
         out_count_ff <= COUNT_WIDTH'($countones(cmp_mask));
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_match_mask  = out_mask_ff;
   assign rsp_match_count = out_count_ff;

endmodule

[rtl/osmc_checker.sv]
// port-level checks for the opcode sample match counter, bound to the top
// depends on osmc_pkg and opcode_sample_match_counter
module osmc_checker
   import osmc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [NUM_OPS-1:0]       rsp_match_mask,
   input logic [COUNT_WIDTH-1:0]   rsp_match_count
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_mask)
                                 && $stable(rsp_match_count))
      else $error("stalled result changed");

   // count always agrees with the mask it travels with
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_match_count == COUNT_WIDTH'($countones(rsp_match_mask)))
      else $error("match count disagrees with mask");

   // reset empties the pipeline
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown straight after reset");

endmodule

bind opcode_sample_match_counter osmc_checker u_osmc_checker (.*);

[tb/testbench.sv]
// self-checking testbench for the opcode sample match counter
// depends on osmc_pkg and the rtl top level opcode_sample_match_counter
`timescale 1ns / 1ps

module testbench;
   import osmc_pkg::*;

   localparam int DIRECTED_COUNT = 23;
   localparam int RANDOM_COUNT   = 900;
   localparam int QUIET_TAIL     = 150;   // last random samples, no idling on either side
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer before giving up
   localparam int DRAIN_CYCLES   = 20;

   typedef logic [NUM_REGS-1:0][FIELD_WIDTH-1:0] field_file_type;
   typedef reg_word_type [NUM_REGS-1:0]          regfile_type;

   // one sample as it crosses the request channel
   typedef struct packed {
      field_file_type prior;
      field_file_type after;
      opnd_type       a;
      opnd_type       b;
      opnd_type       c;
   } tb_sample_type;

   typedef struct packed {
      op_mask_type  mask;
      op_count_type count;
   } match_result_type;

   // predicts the match mask of every sample and checks the results in order
   class match_scoreboard;
      match_result_type pending_q[$];
      int               errors;
      int               checked;
      int               hits;

      function new();
         errors  = 0;
         checked = 0;
         hits    = 0;
      endfunction

      // 32-bit field, sign-extended then cut to register width
      static function reg_word_type widen_field(logic [FIELD_WIDTH-1:0] raw);
         logic [63:0] ext;
         ext = {{(64-FIELD_WIDTH){raw[FIELD_WIDTH-1]}}, raw};
         return reg_word_type'(ext);
      endfunction

      static function regfile_type widen_file(field_file_type raw);
         regfile_type w;
         for (int i = 0; i < NUM_REGS; i++) w[i] = widen_field(raw[i]);
         return w;
      endfunction

      // which operands an operation reads as register indexes
      static function void op_sources(int op, output bit a_reg, output bit b_reg);
         case (op)
            OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTRR, OP_EQRR: begin
               a_reg = 1'b1;
               b_reg = 1'b1;
            end
            OP_GTIR, OP_EQIR: begin
               a_reg = 1'b0;
               b_reg = 1'b1;
            end
            OP_SETI: begin
               a_reg = 1'b0;
               b_reg = 1'b0;
            end
            default: begin
               a_reg = 1'b1;
               b_reg = 1'b0;
            end
         endcase
      endfunction

      // runs one operation on the register file; returns 0 for a bad index
      static function bit run_op(int op, regfile_type regs, opnd_type a, opnd_type b,
                                 opnd_type c, output regfile_type result);
         bit           a_reg;
         bit           b_reg;
         reg_word_type x;
         reg_word_type y;
         reg_word_type r;
         op_sources(op, a_reg, b_reg);
         result = regs;
         if (c >= NUM_REGS || (a_reg && a >= NUM_REGS) || (b_reg && b >= NUM_REGS))
            return 1'b0;
         x = a_reg ? regs[a[REG_IDX_WIDTH-1:0]] : reg_word_type'(64'(a));
         y = b_reg ? regs[b[REG_IDX_WIDTH-1:0]] : reg_word_type'(64'(b));
         case (op)
            OP_ADDR, OP_ADDI: r = x + y;
            OP_MULR, OP_MULI: r = x * y;
            OP_BANR, OP_BANI: r = x & y;
            OP_BORR, OP_BORI: r = x | y;
            OP_SETR, OP_SETI: r = x;
            OP_GTIR, OP_GTRI, OP_GTRR: r = reg_word_type'($signed(x) > $signed(y));
            default: r = reg_word_type'(x == y);
         endcase
         result[c[REG_IDX_WIDTH-1:0]] = r;
         return 1'b1;
      endfunction

      static function match_result_type predict_matches(tb_sample_type s);
         regfile_type      prior_w;
         regfile_type      after_w;
         regfile_type      trial;
         match_result_type r;
         r       = '0;
         prior_w = widen_file(s.prior);
         after_w = widen_file(s.after);
         for (int k = 0; k < NUM_OPS; k++) begin
            if (run_op(k, prior_w, s.a, s.b, s.c, trial) && trial == after_w) begin
               r.mask[k] = 1'b1;
               r.count++;
            end
         end
         return r;
      endfunction

      function void note_sample(tb_sample_type s);
         pending_q.push_back(predict_matches(s));
      endfunction

      function void check_result(op_mask_type mask, op_count_type count);
         match_result_type want;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing pending, mask %h count %0d", $time, mask, count);
            return;
         end
         want = pending_q.pop_front();
         checked++;
         if (want.mask != 0) hits++;
         if (mask !== want.mask) begin
            errors++;
            $display("%0t: match_mask expected %h actual %h", $time, want.mask, mask);
         end
         if (count !== want.count) begin
            errors++;
            $display("%0t: match_count expected %0d actual %0d", $time, want.count, count);
         end
      endfunction

      function int pending();
         return pending_q.size();
      endfunction
   endclass

   // dut signals, all inputs known from time zero
   logic                          clock;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic signed [FIELD_WIDTH-1:0] req_before_r0   = '0;
   logic signed [FIELD_WIDTH-1:0] req_before_r1   = '0;
   logic signed [FIELD_WIDTH-1:0] req_before_r2   = '0;
   logic signed [FIELD_WIDTH-1:0] req_before_r3   = '0;
   logic        [OPND_WIDTH-1:0]  req_operand_a   = '0;
   logic        [OPND_WIDTH-1:0]  req_operand_b   = '0;
   logic        [OPND_WIDTH-1:0]  req_operand_c   = '0;
   logic signed [FIELD_WIDTH-1:0] req_after_r0    = '0;
   logic signed [FIELD_WIDTH-1:0] req_after_r1    = '0;
   logic signed [FIELD_WIDTH-1:0] req_after_r2    = '0;
   logic signed [FIELD_WIDTH-1:0] req_after_r3    = '0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic        [NUM_OPS-1:0]     rsp_match_mask;
   logic        [COUNT_WIDTH-1:0] rsp_match_count;

   match_scoreboard sb;
   bit              rsp_stalls_on = 1'b1;  // cleared for the quiet tail of the run
   int              samples_sent  = 0;

   opcode_sample_match_counter u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_before_r0   (req_before_r0),
      .req_before_r1   (req_before_r1),
      .req_before_r2   (req_before_r2),
      .req_before_r3   (req_before_r3),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .req_operand_c   (req_operand_c),
      .req_after_r0    (req_after_r0),
      .req_after_r1    (req_after_r1),
      .req_after_r2    (req_after_r2),
      .req_after_r3    (req_after_r3),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match_mask  (rsp_match_mask),
      .rsp_match_count (rsp_match_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- stimulus helpers

   // register values biased towards the corners of the signed range
   function automatic logic [FIELD_WIDTH-1:0] random_word();
      logic [FIELD_WIDTH-1:0] w;
      case ($urandom_range(0, 9))
         0: w = '0;
         1: w = '1;
         2: w = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
         3: w = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
         4, 5: w = FIELD_WIDTH'($urandom_range(0, 12));
         6: w = -FIELD_WIDTH'($urandom_range(1, 12));
         default: w = $urandom;
      endcase
      return w;
   endfunction

   function automatic opnd_type random_imm();
      opnd_type v;
      case ($urandom_range(0, 5))
         0, 1, 2: v = opnd_type'($urandom_range(0, 7));
         3: v = '1;
         default: v = opnd_type'($urandom);
      endcase
      return v;
   endfunction

   // sample whose after state is what op does to the prior state
   function automatic tb_sample_type sample_for(int op, field_file_type prior, opnd_type a,
                                                opnd_type b, opnd_type c);
      tb_sample_type s;
      regfile_type   result;
      s.prior = prior;
      s.a     = a;
      s.b     = b;
      s.c     = c;
      s.after = prior;
      if (match_scoreboard::run_op(op, match_scoreboard::widen_file(prior), a, b, c, result))
         for (int i = 0; i < NUM_REGS; i++)
            s.after[i] = FIELD_WIDTH'($signed(result[i]));
      return s;
   endfunction

   // a well-formed instruction with random content
   function automatic tb_sample_type random_legal();
      int             op;
      bit             a_reg;
      bit             b_reg;
      field_file_type prior;
      opnd_type       a;
      opnd_type       b;
      op = $urandom_range(0, NUM_OPS - 1);
      match_scoreboard::op_sources(op, a_reg, b_reg);
      for (int i = 0; i < NUM_REGS; i++) prior[i] = random_word();
      a = a_reg ? opnd_type'($urandom_range(0, NUM_REGS - 1)) : random_imm();
      b = b_reg ? opnd_type'($urandom_range(0, NUM_REGS - 1)) : random_imm();
      return sample_for(op, prior, a, b, opnd_type'($urandom_range(0, NUM_REGS - 1)));
   endfunction

   function automatic tb_sample_type random_sample();
      tb_sample_type s;
      int            pick;
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
         // clean instruction, now and then one after bit flipped for a near miss
         s = random_legal();
         if ($urandom_range(0, 7) == 0)
            s.after[$urandom_range(0, NUM_REGS - 1)][$urandom_range(0, FIELD_WIDTH - 1)] ^= 1'b1;
      end else if (pick < 14) begin
         // pure noise over every field
         for (int i = 0; i < NUM_REGS; i++) begin
            s.prior[i] = $urandom;
            s.after[i] = $urandom;
         end
         s.a = opnd_type'($urandom);
         s.b = opnd_type'($urandom);
         s.c = opnd_type'($urandom);
      end else if (pick < 17) begin
         // broken instruction, one operand pushed out of the register range
         s = random_legal();
         case ($urandom_range(0, 2))
            0: s.a = opnd_type'($urandom_range(NUM_REGS, 65535));
            1: s.b = opnd_type'($urandom_range(NUM_REGS, 65535));
            default: s.c = opnd_type'($urandom_range(NUM_REGS, 65535));
         endcase
      end else begin
         // register file unchanged, catches set and and/or no-ops
         s = random_legal();
         s.after = s.prior;
      end
      return s;
   endfunction

   function automatic tb_sample_type directed_sample(int idx);
      field_file_type corners;
      field_file_type prior;
      bit             a_reg;
      bit             b_reg;
      tb_sample_type  s;
      corners = {{1'b1, {(FIELD_WIDTH-1){1'b0}}}, {1'b0, {(FIELD_WIDTH-1){1'b1}}},
                 {FIELD_WIDTH{1'b1}}, {FIELD_WIDTH{1'b0}}};
      for (int i = 0; i < NUM_REGS; i++) prior[(i + idx) % NUM_REGS] = corners[i];
      if (idx < NUM_OPS) begin
         // every operation on the signed corners, immediates and the unused b at all ones
         match_scoreboard::op_sources(idx, a_reg, b_reg);
         return sample_for(idx, prior,
                           a_reg ? opnd_type'(idx % NUM_REGS) : '1,
                           b_reg ? opnd_type'((idx + 1) % NUM_REGS) : '1,
                           opnd_type'((idx + 2) % NUM_REGS));
      end
      case (idx)
         16: begin
            // destination just past the last register
            s   = sample_for(OP_ADDR, prior, opnd_type'(0), opnd_type'(1), opnd_type'(2));
            s.c = opnd_type'(NUM_REGS);
         end
         17: begin
            // register source a just out of range
            s   = sample_for(OP_MULR, prior, opnd_type'(0), opnd_type'(1), opnd_type'(3));
            s.a = opnd_type'(NUM_REGS);
         end
         18: begin
            // register source b just out of range
            s   = sample_for(OP_BORR, prior, opnd_type'(2), opnd_type'(3), opnd_type'(0));
            s.b = opnd_type'(NUM_REGS);
         end
         19: begin
            // destination at all ones
            s   = sample_for(OP_SETI, prior, '1, '1, opnd_type'(1));
            s.c = '1;
         end
         20: s = '0;  // all zero, most operations match at once
         21: begin
            // setr onto itself with b out of range, b must not matter
            s       = sample_for(OP_SETR, prior, opnd_type'(2), '1, opnd_type'(2));
            s.after = s.prior;
         end
         default: begin
            // product that wraps well past the register width
            prior[0] = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
            s = sample_for(OP_MULI, prior, opnd_type'(0), '1, opnd_type'(0));
         end
      endcase
      return s;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic drive_sample(tb_sample_type s, bit allow_gap);
      if (allow_gap && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_before_r0 <= s.prior[0];
      req_before_r1 <= s.prior[1];
      req_before_r2 <= s.prior[2];
      req_before_r3 <= s.prior[3];
      req_operand_a <= s.a;
      req_operand_b <= s.b;
      req_operand_c <= s.c;
      req_after_r0  <= s.after[0];
      req_after_r1  <= s.after[1];
      req_after_r2  <= s.after[2];
      req_after_r3  <= s.after[3];
      // hold the sample until the transfer
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   // sender stands still until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // result side: ready in random bursts with random low stretches
   initial begin
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (rsp_stalls_on && $urandom_range(0, 1) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // both channels sampled at the edge, before any driver update lands
   always @(posedge clock) begin
      tb_sample_type s;
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_match_mask, rsp_match_count);
         if (req_valid && req_ready) begin
            s.prior = {req_before_r3, req_before_r2, req_before_r1, req_before_r0};
            s.after = {req_after_r3, req_after_r2, req_after_r1, req_after_r0};
            s.a     = req_operand_a;
            s.b     = req_operand_b;
            s.c     = req_operand_c;
            sb.note_sample(s);
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed corners, back to back
      for (int i = 0; i < DIRECTED_COUNT; i++) drive_sample(directed_sample(i), 1'b0);
      drain_results();

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i == RANDOM_COUNT / 2) drain_results();
         if (i == RANDOM_COUNT - QUIET_TAIL) rsp_stalls_on = 1'b0;
         drive_sample(random_sample(), i < RANDOM_COUNT - QUIET_TAIL);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("%0t: %0d match results never arrived", $time, sb.pending());
      end

      $display("sent %0d samples (corners, clean, near-miss, broken, noise), checked %0d results",
               samples_sent, sb.checked);
      $display("%0d results had at least one matching operation", sb.hits);
      if (sb.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
